/* rtl/scc_pkg.sv */
// Shared types and constants for the strongly connected components block.
// Used by the controller, the datapath and the top level; no dependencies.
package scc_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_EDGES_DEF = 4096;

    // Fixed field widths of the item ports
    localparam int FUNC_W = 2;
    localparam int NODE_W = 11;
    localparam int STAT_W = 2;
    localparam int COMP_W = 10;

    // Function codes of an input item
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

    // Status codes of a result item
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_CLR_START, OP_CLR_LIST, OP_ADD_RD, OP_ADD_W1, OP_ADD_W2,
        OP_RESP_OK, OP_RESP_BAD, OP_RESP_EMPTY, OP_RD_ADDR, OP_RD_RESP, OP_RUN_INIT,
        OP_CLR_MARK, OP_ROOT_RD, OP_ROOT_NEXT, OP_ENTER_ROOT, OP_ENTER_CHILD,
        OP_ENTER_WR, OP_EDGE_RD, OP_EDGE_GOT, OP_EDGE_W, OP_SCAN_INIT, OP_SCAN_RD,
        OP_EMIT_INIT, OP_EMIT_RD, OP_EMIT_WR, OP_COMP_DONE, OP_POP, OP_POP_GOT,
        OP_POP_LOW
    } cmd_t;

    // Conditions reported by the datapath
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic add_ok;
        logic rd_avail;
        logic sweep_last;
        logic root_done;
        logic seen;
        logic e_valid;
        logic w_bad;
        logic w_room;
        logic is_root;
        logic k_zero;
        logic found;
        logic emit_done;
        logic sp_one;
    } dp_stat_t;

endpackage

/* rtl/strongly_connected_components.sv */
// Top level of the strongly connected components search block.
// Depends on scc_pkg, scc_ctrl, scc_dp (and scc_ram through scc_dp).
//
//   port group   direction   handshake              carries
//   s_*          in          s_valid / s_ready      func, edge_source, edge_destination
//   m_*          out         m_valid / m_ready      status, node, component, flags, total
//   cfg_*        in          cfg_wr_en              node_count
//
// Accepted adds pass through dispatch, an edge list read and the list and link writes
// before the response; a read takes dispatch and an output list read; a rejected add or
// empty read responds from dispatch; clear sweeps the edge list store. A run clears the
// marks, then walks every edge and node, waiting on read round trips of the stack and
// mark memories. After reset the edge list store is swept before s_ready rises. One item
// is in work at a time; s_ready stays low until the previous result has been taken.
module strongly_connected_components import scc_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [NODE_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [FUNC_W-1:0] s_func,
    input  logic [NODE_W-1:0] s_edge_source,
    input  logic [NODE_W-1:0] s_edge_destination,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [NODE_W-1:0] m_node_id,
    output logic [COMP_W-1:0] m_component_index,
    output logic              m_last_in_component,
    output logic              m_last_overall,
    output logic [NODE_W-1:0] m_component_total
);
    cmd_t     cmd;
    dp_stat_t stat;

    // Sequence the work
    scc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    // Hold the graph and run the search steps
    scc_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_func(s_func), .s_edge_source(s_edge_source),
        .s_edge_destination(s_edge_destination),
        .m_status(m_status), .m_node_id(m_node_id),
        .m_component_index(m_component_index),
        .m_last_in_component(m_last_in_component),
        .m_last_overall(m_last_overall), .m_component_total(m_component_total)
    );
endmodule

/* rtl/scc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* rtl/scc_ctrl.sv */
// Controller state machine: sequences edge loads, reads, clears and the search.
// Depends on scc_pkg; drives scc_dp through cmd_t and reads dp_stat_t.
module scc_ctrl import scc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output cmd_t     cmd
);
    typedef enum logic [4:0] {
        ST_RST_SWEEP, ST_IDLE, ST_DISPATCH, ST_CLR_SWEEP, ST_ADD_W1, ST_ADD_W2, ST_RESP,
        ST_RD_RESP, ST_MARK_SWEEP, ST_ROOT, ST_ROOT_CHK, ST_ENTER_WR, ST_LOOP,
        ST_EDGE_GOT, ST_EDGE_CHK, ST_SCAN_RD, ST_SCAN_CHK, ST_EMIT_INIT, ST_EMIT,
        ST_EMIT_WR, ST_POP, ST_POP_GOT, ST_POP_LOW
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg;
    logic   resp_fire;

    assign s_ready   = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid   = m_valid_reg;
    assign resp_fire = (cmd == OP_RESP_OK) || (cmd == OP_RESP_BAD) ||
                       (cmd == OP_RESP_EMPTY) || (cmd == OP_RD_RESP);

    // Pick the operation and the next state
    always_comb begin
        cmd        = OP_NONE;
        state_next = state_reg;
        case (state_reg)
            ST_RST_SWEEP: begin
                cmd = OP_CLR_LIST;
                if (stat.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd        = OP_LATCH;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.func)
                    FUNC_ADD: begin
                        if (stat.add_ok) begin
                            cmd        = OP_ADD_RD;
                            state_next = ST_ADD_W1;
                        end else begin
                            cmd        = OP_RESP_BAD;
                            state_next = ST_IDLE;
                        end
                    end
                    FUNC_RUN: begin
                        cmd        = OP_RUN_INIT;
                        state_next = ST_MARK_SWEEP;
                    end
                    FUNC_READ: begin
                        if (stat.rd_avail) begin
                            cmd        = OP_RD_ADDR;
                            state_next = ST_RD_RESP;
                        end else begin
                            cmd        = OP_RESP_EMPTY;
                            state_next = ST_IDLE;
                        end
                    end
                    default: begin
                        cmd        = OP_CLR_START;
                        state_next = ST_CLR_SWEEP;
                    end
                endcase
            end
            ST_CLR_SWEEP: begin
                cmd = OP_CLR_LIST;
                if (stat.sweep_last) state_next = ST_RESP;
            end
            ST_ADD_W1: begin
                cmd        = OP_ADD_W1;
                state_next = ST_ADD_W2;
            end
            ST_ADD_W2: begin
                cmd        = OP_ADD_W2;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                cmd        = OP_RESP_OK;
                state_next = ST_IDLE;
            end
            ST_RD_RESP: begin
                cmd        = OP_RD_RESP;
                state_next = ST_IDLE;
            end
            ST_MARK_SWEEP: begin
                cmd = OP_CLR_MARK;
                if (stat.sweep_last) state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (stat.root_done) begin
                    cmd        = OP_RESP_OK;
                    state_next = ST_IDLE;
                end else begin
                    cmd        = OP_ROOT_RD;
                    state_next = ST_ROOT_CHK;
                end
            end
            ST_ROOT_CHK: begin
                if (stat.seen) begin
                    cmd        = OP_ROOT_NEXT;
                    state_next = ST_ROOT;
                end else begin
                    cmd        = OP_ENTER_ROOT;
                    state_next = ST_ENTER_WR;
                end
            end
            ST_ENTER_WR: begin
                cmd        = OP_ENTER_WR;
                state_next = ST_LOOP;
            end
            ST_LOOP: begin
                if (stat.e_valid) begin
                    cmd        = OP_EDGE_RD;
                    state_next = ST_EDGE_GOT;
                end else if (stat.is_root) begin
                    cmd        = OP_SCAN_INIT;
                    state_next = ST_SCAN_RD;
                end else begin
                    cmd        = OP_POP;
                    state_next = stat.sp_one ? ST_ROOT : ST_POP_GOT;
                end
            end
            ST_EDGE_GOT: begin
                cmd        = OP_EDGE_GOT;
                state_next = stat.w_bad ? ST_LOOP : ST_EDGE_CHK;
            end
            ST_EDGE_CHK: begin
                if (stat.seen) begin
                    cmd        = OP_EDGE_W;
                    state_next = ST_LOOP;
                end else if (stat.w_room) begin
                    cmd        = OP_ENTER_CHILD;
                    state_next = ST_ENTER_WR;
                end else begin
                    state_next = ST_LOOP;
                end
            end
            ST_SCAN_RD: begin
                if (stat.k_zero) begin
                    state_next = ST_EMIT_INIT;
                end else begin
                    cmd        = OP_SCAN_RD;
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                state_next = stat.found ? ST_EMIT_INIT : ST_SCAN_RD;
            end
            ST_EMIT_INIT: begin
                cmd        = OP_EMIT_INIT;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.emit_done) begin
                    cmd        = OP_COMP_DONE;
                    state_next = ST_POP;
                end else begin
                    cmd        = OP_EMIT_RD;
                    state_next = ST_EMIT_WR;
                end
            end
            ST_EMIT_WR: begin
                cmd        = OP_EMIT_WR;
                state_next = ST_EMIT;
            end
            ST_POP: begin
                cmd        = OP_POP;
                state_next = stat.sp_one ? ST_ROOT : ST_POP_GOT;
            end
            ST_POP_GOT: begin
                cmd        = OP_POP_GOT;
                state_next = ST_POP_LOW;
            end
            ST_POP_LOW: begin
                cmd        = OP_POP_LOW;
                state_next = ST_LOOP;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RST_SWEEP;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (resp_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end
endmodule

/* rtl/scc_dp.sv */
// Datapath: graph memories, search stacks, counters and result registers.
// Depends on scc_pkg and scc_ram; executes one cmd_t per cycle.
module scc_dp import scc_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output dp_stat_t          stat,
    input  logic              cfg_wr_en,
    input  logic [NODE_W-1:0] cfg_wr_data,
    input  logic [FUNC_W-1:0] s_func,
    input  logic [NODE_W-1:0] s_edge_source,
    input  logic [NODE_W-1:0] s_edge_destination,
    output logic [STAT_W-1:0] m_status,
    output logic [NODE_W-1:0] m_node_id,
    output logic [COMP_W-1:0] m_component_index,
    output logic              m_last_in_component,
    output logic              m_last_overall,
    output logic [NODE_W-1:0] m_component_total
);
    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int SAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam logic [EW-1:0] NO_EDGE = EW'(MAX_EDGES);

    // Control and working registers
    logic [NODE_W-1:0] node_count_reg, src_reg, dst_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [EW-1:0]     edge_total_reg, e_reg;
    logic [NW-1:0]     cnt_reg, time_reg, out_count_reg, comp_count_reg;
    logic [NW-1:0]     rd_ptr_reg, rd_comp_reg, sp_reg, nsp_reg, k_reg, j_reg;
    logic [NW-1:0]     x_reg, v_reg, w_reg, lowv_reg, discv_reg, child_low_reg;
    logic [NW:0]       r_reg;

    // Memory ports
    logic [2*EW-1:0] list_rdata, list_wdata;
    logic [NW-1:0]   list_waddr, list_raddr;
    logic            list_we, list_re;
    logic [NW-1:0]   tgt_rdata;
    logic [EW-1:0]   nxt_rdata, nxt_wdata;
    logic [EAW-1:0]  nxt_waddr;
    logic            nxt_we, edge_re;
    logic [NW-1:0]   disc_rdata, disc_wdata, mark_waddr, mark_raddr;
    logic            disc_we, mark_re;
    logic [NW-1:0]   low_rdata, low_wdata, low_waddr;
    logic            low_we;
    logic            onstk_rdata, onstk_wdata, onstk_we;
    logic [NW-1:0]   onstk_waddr;
    logic [NW+EW-1:0] call_rdata, call_wdata;
    logic [SAW-1:0]  call_waddr;
    logic            call_we, call_re;
    logic [NW-1:0]   ns_rdata;
    logic [SAW-1:0]  ns_raddr;
    logic            ns_re, ns_we;
    logic [NW:0]     out_rdata;
    logic            out_we, out_re;

    logic [NW-1:0] n_eff, t_next, sp_m1, sp_m2, k_m1, new_low;
    logic [EW-1:0] head, tail;
    logic          tail_valid, child_lower;

    assign n_eff = (32'(node_count_reg) > 32'(MAX_NODES)) ? NW'(MAX_NODES)
                                                          : NW'(node_count_reg);
    assign head        = list_rdata[2*EW-1:EW];
    assign tail        = list_rdata[EW-1:0];
    assign tail_valid  = 32'(tail) < 32'(MAX_EDGES);
    assign t_next      = time_reg + NW'(1);
    assign sp_m1       = sp_reg - NW'(1);
    assign sp_m2       = sp_reg - NW'(2);
    assign k_m1        = k_reg - NW'(1);
    assign child_lower = child_low_reg < low_rdata;
    assign new_low     = child_lower ? child_low_reg : low_rdata;

    // Report conditions to the controller
    always_comb begin
        stat.func       = func_reg;
        stat.add_ok     = (src_reg != '0) && (32'(src_reg) <= 32'(n_eff)) &&
                          (dst_reg != '0) && (32'(dst_reg) <= 32'(n_eff)) &&
                          (32'(edge_total_reg) < 32'(MAX_EDGES));
        stat.rd_avail   = rd_ptr_reg < out_count_reg;
        stat.sweep_last = cnt_reg == NW'(MAX_NODES);
        stat.root_done  = r_reg > {1'b0, n_eff};
        stat.seen       = disc_rdata != '0;
        stat.e_valid    = 32'(e_reg) < 32'(MAX_EDGES);
        stat.w_bad      = (tgt_rdata == '0) || (tgt_rdata > n_eff);
        stat.w_room     = (32'(sp_reg) < 32'(MAX_NODES)) && (32'(nsp_reg) < 32'(MAX_NODES));
        stat.is_root    = lowv_reg == discv_reg;
        stat.k_zero     = k_reg == '0;
        stat.found      = ns_rdata == v_reg;
        stat.emit_done  = j_reg == nsp_reg;
        stat.sp_one     = sp_reg == NW'(1);
    end

    // Steer memory ports
    always_comb begin
        list_we    = (cmd == OP_CLR_LIST) || (cmd == OP_ADD_W1);
        list_waddr = (cmd == OP_CLR_LIST) ? cnt_reg : NW'(src_reg);
        list_wdata = (cmd == OP_CLR_LIST) ? {NO_EDGE, NO_EDGE}
                                          : {tail_valid ? head : edge_total_reg,
                                             edge_total_reg};
        list_re    = (cmd == OP_ADD_RD) || (cmd == OP_ENTER_ROOT) ||
                     (cmd == OP_ENTER_CHILD);
        case (cmd)
            OP_ADD_RD:     list_raddr = NW'(src_reg);
            OP_ENTER_ROOT: list_raddr = r_reg[NW-1:0];
            default:       list_raddr = w_reg;
        endcase

        nxt_we    = (cmd == OP_ADD_W1) || ((cmd == OP_ADD_W2) && tail_valid);
        nxt_waddr = (cmd == OP_ADD_W1) ? edge_total_reg[EAW-1:0] : tail[EAW-1:0];
        nxt_wdata = (cmd == OP_ADD_W1) ? NO_EDGE : edge_total_reg;
        edge_re   = cmd == OP_EDGE_RD;

        mark_re = (cmd == OP_ROOT_RD) || (cmd == OP_EDGE_GOT) || (cmd == OP_POP_GOT);
        case (cmd)
            OP_ROOT_RD:  mark_raddr = r_reg[NW-1:0];
            OP_EDGE_GOT: mark_raddr = tgt_rdata;
            default:     mark_raddr = call_rdata[NW+EW-1:EW];
        endcase
        mark_waddr = (cmd == OP_CLR_MARK) ? cnt_reg : x_reg;
        disc_we    = (cmd == OP_CLR_MARK) || (cmd == OP_ENTER_WR);
        disc_wdata = (cmd == OP_CLR_MARK) ? '0 : t_next;

        low_we = 1'b0;
        low_waddr = mark_waddr;
        low_wdata = disc_wdata;
        case (cmd)
            OP_CLR_MARK, OP_ENTER_WR: low_we = 1'b1;
            OP_EDGE_W: begin
                low_we    = onstk_rdata && (disc_rdata < lowv_reg);
                low_waddr = v_reg;
                low_wdata = disc_rdata;
            end
            OP_POP_LOW: begin
                low_we    = child_lower;
                low_waddr = v_reg;
                low_wdata = child_low_reg;
            end
            default: low_we = 1'b0;
        endcase

        onstk_we    = (cmd == OP_CLR_MARK) || (cmd == OP_ENTER_WR) || (cmd == OP_EMIT_WR);
        onstk_waddr = (cmd == OP_EMIT_WR) ? ns_rdata : mark_waddr;
        onstk_wdata = cmd == OP_ENTER_WR;

        call_we    = (cmd == OP_ENTER_WR) || (cmd == OP_EDGE_GOT);
        call_waddr = (cmd == OP_ENTER_WR) ? sp_reg[SAW-1:0] : sp_m1[SAW-1:0];
        call_wdata = (cmd == OP_ENTER_WR) ? {x_reg, head} : {v_reg, nxt_rdata};
        call_re    = cmd == OP_POP;

        ns_we    = cmd == OP_ENTER_WR;
        ns_re    = (cmd == OP_SCAN_RD) || (cmd == OP_EMIT_RD);
        ns_raddr = (cmd == OP_SCAN_RD) ? k_m1[SAW-1:0] : j_reg[SAW-1:0];

        out_we = (cmd == OP_EMIT_WR) && (32'(out_count_reg) < 32'(MAX_NODES));
        out_re = cmd == OP_RD_ADDR;
    end

    // Advance registers per operation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_W'(1);
            edge_total_reg <= '0;
            cnt_reg        <= '0;
            time_reg       <= '0;
            out_count_reg  <= '0;
            comp_count_reg <= '0;
            rd_ptr_reg     <= '0;
            rd_comp_reg    <= '0;
        end else begin
            if (cfg_wr_en) node_count_reg <= cfg_wr_data;
            case (cmd)
                OP_LATCH: begin
                    func_reg <= s_func;
                    src_reg  <= s_edge_source;
                    dst_reg  <= s_edge_destination;
                end
                OP_CLR_START: begin
                    cnt_reg        <= '0;
                    edge_total_reg <= '0;
                end
                OP_CLR_LIST, OP_CLR_MARK: begin
                    if (cnt_reg != NW'(MAX_NODES)) cnt_reg <= cnt_reg + NW'(1);
                end
                OP_ADD_W2: edge_total_reg <= edge_total_reg + EW'(1);
                OP_RUN_INIT: begin
                    cnt_reg        <= '0;
                    time_reg       <= '0;
                    out_count_reg  <= '0;
                    comp_count_reg <= '0;
                    rd_ptr_reg     <= '0;
                    rd_comp_reg    <= '0;
                    r_reg          <= (NW + 1)'(1);
                    sp_reg         <= '0;
                    nsp_reg        <= '0;
                end
                OP_ROOT_NEXT: r_reg <= r_reg + (NW + 1)'(1);
                OP_ENTER_ROOT: x_reg <= r_reg[NW-1:0];
                OP_ENTER_CHILD: x_reg <= w_reg;
                OP_ENTER_WR: begin
                    time_reg  <= t_next;
                    nsp_reg   <= nsp_reg + NW'(1);
                    sp_reg    <= sp_reg + NW'(1);
                    v_reg     <= x_reg;
                    e_reg     <= head;
                    lowv_reg  <= t_next;
                    discv_reg <= t_next;
                end
                OP_EDGE_GOT: begin
                    w_reg <= tgt_rdata;
                    e_reg <= nxt_rdata;
                end
                OP_EDGE_W: begin
                    if (onstk_rdata && (disc_rdata < lowv_reg)) lowv_reg <= disc_rdata;
                end
                OP_SCAN_INIT: k_reg <= nsp_reg;
                OP_SCAN_RD: k_reg <= k_m1;
                OP_EMIT_INIT: j_reg <= k_reg;
                OP_EMIT_WR: begin
                    if (32'(out_count_reg) < 32'(MAX_NODES)) begin
                        out_count_reg <= out_count_reg + NW'(1);
                    end
                    j_reg <= j_reg + NW'(1);
                end
                OP_COMP_DONE: begin
                    nsp_reg        <= k_reg;
                    comp_count_reg <= comp_count_reg + NW'(1);
                end
                OP_POP: begin
                    sp_reg <= sp_m1;
                    if (sp_reg == NW'(1)) r_reg <= r_reg + (NW + 1)'(1);
                end
                OP_POP_GOT: begin
                    v_reg         <= call_rdata[NW+EW-1:EW];
                    e_reg         <= call_rdata[EW-1:0];
                    child_low_reg <= lowv_reg;
                end
                OP_POP_LOW: begin
                    lowv_reg  <= new_low;
                    discv_reg <= disc_rdata;
                end
                OP_RD_RESP: begin
                    rd_ptr_reg <= rd_ptr_reg + NW'(1);
                    if (out_rdata[0]) rd_comp_reg <= rd_comp_reg + NW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Load the result registers
    always_ff @(posedge aclk) begin
        case (cmd)
            OP_RESP_OK, OP_RESP_BAD, OP_RESP_EMPTY: begin
                m_status            <= (cmd == OP_RESP_OK)  ? STAT_OK :
                                       (cmd == OP_RESP_BAD) ? STAT_BAD : STAT_EMPTY;
                m_node_id           <= '0;
                m_component_index   <= '0;
                m_last_in_component <= 1'b0;
                m_last_overall      <= 1'b0;
                m_component_total   <= NODE_W'(comp_count_reg);
            end
            OP_RD_RESP: begin
                m_status            <= STAT_OK;
                m_node_id           <= NODE_W'(out_rdata[NW:1]);
                m_component_index   <= COMP_W'(rd_comp_reg);
                m_last_in_component <= out_rdata[0];
                m_last_overall      <= (rd_ptr_reg + NW'(1)) == out_count_reg;
                m_component_total   <= NODE_W'(comp_count_reg);
            end
            default: begin
            end
        endcase
    end

    // Per-node edge list heads and tails
    scc_ram #(.WIDTH(2 * EW), .DEPTH(MAX_NODES + 1)) u_list (
        .aclk(aclk), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
        .re(list_re), .raddr(list_raddr), .rdata(list_rdata)
    );

    // Edge targets and next links
    scc_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_target (
        .aclk(aclk), .we(cmd == OP_ADD_W1), .waddr(edge_total_reg[EAW-1:0]),
        .wdata(NW'(dst_reg)), .re(edge_re), .raddr(e_reg[EAW-1:0]), .rdata(tgt_rdata)
    );
    scc_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_next (
        .aclk(aclk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .re(edge_re), .raddr(e_reg[EAW-1:0]), .rdata(nxt_rdata)
    );

    // Discovery index, low link and on-stack marks
    scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES + 1)) u_disc (
        .aclk(aclk), .we(disc_we), .waddr(mark_waddr), .wdata(disc_wdata),
        .re(mark_re), .raddr(mark_raddr), .rdata(disc_rdata)
    );
    scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES + 1)) u_low (
        .aclk(aclk), .we(low_we), .waddr(low_waddr), .wdata(low_wdata),
        .re(mark_re), .raddr(mark_raddr), .rdata(low_rdata)
    );
    scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES + 1)) u_onstk (
        .aclk(aclk), .we(onstk_we), .waddr(onstk_waddr), .wdata(onstk_wdata),
        .re(mark_re), .raddr(mark_raddr), .rdata(onstk_rdata)
    );

    // Call stack, node stack and recorded output list
    scc_ram #(.WIDTH(NW + EW), .DEPTH(MAX_NODES)) u_call (
        .aclk(aclk), .we(call_we), .waddr(call_waddr), .wdata(call_wdata),
        .re(call_re), .raddr(sp_m2[SAW-1:0]), .rdata(call_rdata)
    );
    scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_nstack (
        .aclk(aclk), .we(ns_we), .waddr(nsp_reg[SAW-1:0]), .wdata(x_reg),
        .re(ns_re), .raddr(ns_raddr), .rdata(ns_rdata)
    );
    scc_ram #(.WIDTH(NW + 1), .DEPTH(MAX_NODES)) u_out (
        .aclk(aclk), .we(out_we), .waddr(out_count_reg[SAW-1:0]),
        .wdata({ns_rdata, (j_reg + NW'(1)) == nsp_reg}),
        .re(out_re), .raddr(rd_ptr_reg[SAW-1:0]), .rdata(out_rdata)
    );
endmodule
